/* rtl/tcd_pkg.sv */
// Package for the Telnet command deframer: protocol codes, phase, kind and slot types.
package tcd_pkg;

    localparam int SUB_LEN_DEFAULT = 64;

    localparam logic [7:0] IAC      = 8'd255;
    localparam logic [7:0] CMD_DONT = 8'd254;
    localparam logic [7:0] CMD_DO   = 8'd253;
    localparam logic [7:0] CMD_WONT = 8'd252;
    localparam logic [7:0] CMD_WILL = 8'd251;
    localparam logic [7:0] CMD_SB   = 8'd250;
    localparam logic [7:0] CMD_IP   = 8'd244;
    localparam logic [7:0] CMD_BRK  = 8'd243;
    localparam logic [7:0] CMD_SE   = 8'd240;

    localparam logic [7:0] OPT_BINARY    = 8'd0;
    localparam logic [7:0] OPT_ECHO      = 8'd1;
    localparam logic [7:0] OPT_SUP_GA    = 8'd3;
    localparam logic [7:0] OPT_NAWS      = 8'd31;
    localparam logic [7:0] OPT_REFUSE_LO = 8'd32;
    localparam logic [7:0] OPT_REFUSE_HI = 8'd39;

    typedef enum logic [4:0] {
        PH_IDLE    = 5'b00001,
        PH_IAC     = 5'b00010,
        PH_OPT     = 5'b00100,
        PH_SUB     = 5'b01000,
        PH_SUB_IAC = 5'b10000
    } t_phase;

    typedef enum logic [1:0] {
        KIND_DATA   = 2'd0,
        KIND_REPLY  = 2'd1,
        KIND_STATUS = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        SLOT_IAC  = 2'd0,
        SLOT_RESP = 2'd1,
        SLOT_OPT  = 2'd2
    } t_slot;

endpackage

/* rtl/telnet_command_deframer.sv */
// Telnet command deframer: splits data from IAC sequences and answers negotiation.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+---------------------------------------
//  in      | input     | i_in_valid / o_in_ready    | i_in_byte
//  cfg     | input     | i_cfg_valid / o_cfg_ready  | i_cfg_data (basic_mode)
//  out     | output    | o_out_valid / i_out_ready  | o_out_kind, o_out_byte, o_out_last,
//          |           |                            | window, echo, break, command count
//
//  A byte is parsed in the cycle it is accepted and its first result appears the next cycle.
//  Data and status bytes sustain one byte per cycle while i_out_ready is high; a negotiation
//  reply is three results, so input is held off while the reply register drains.
//  o_in_ready is high when the result register is empty or its last result is taken.
//  Synchronous active-low reset returns the parser to idle data mode; cfg is always ready.
module telnet_command_deframer #(
    parameter int SUB_LEN = tcd_pkg::SUB_LEN_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_in_byte,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_out_kind,
    output logic [7:0]  o_out_byte,
    output logic        o_out_last,
    output logic [15:0] o_window_cols,
    output logic [15:0] o_window_rows,
    output logic        o_server_echo,
    output logic        o_break_request,
    output logic [15:0] o_command_count
);
    import tcd_pkg::*;

    localparam int SUB_W = $clog2(SUB_LEN);

    t_phase           r_phase,   n_phase;
    logic [7:0]       r_cmd,     n_cmd;
    logic [7:0]       r_opt,     n_opt;
    logic [SUB_W-1:0] r_sub_idx, n_sub_idx;
    logic [7:0]       r_sub [4];
    logic [7:0]       n_sub [4];
    logic [15:0]      r_cols,    n_cols;
    logic [15:0]      r_rows,    n_rows;
    logic             r_echo,    n_echo;
    logic [15:0]      r_count,   n_count;
    logic             r_basic;

    logic             r_out_valid;
    logic             r_reply,   n_reply;
    t_kind            r_kind,    n_kind;
    logic [7:0]       r_byte,    n_byte;
    logic [7:0]       r_resp,    n_resp;
    logic             r_brk,     n_brk;
    t_slot            r_slot;

    logic             in_acc;
    logic             out_acc;
    logic             store;
    logic             cmd_byte;
    logic             run_cmd;
    logic [7:0]       run_code;
    logic [7:0]       run_opt;

    assign o_out_last  = !r_reply || (r_slot == SLOT_OPT);
    assign out_acc     = r_out_valid && i_out_ready;
    assign o_in_ready  = !r_out_valid || (i_out_ready && o_out_last);
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_phase   = r_phase;
        n_cmd     = r_cmd;
        n_opt     = r_opt;
        n_sub_idx = r_sub_idx;
        n_sub     = r_sub;
        n_cols    = r_cols;
        n_rows    = r_rows;
        n_echo    = r_echo;
        n_count   = r_count;
        n_reply   = 1'b0;
        n_kind    = KIND_STATUS;
        n_byte    = 8'd0;
        n_resp    = 8'd0;
        n_brk     = 1'b0;
        store     = 1'b0;
        cmd_byte  = 1'b0;
        run_cmd   = 1'b0;
        run_code  = r_cmd;
        run_opt   = r_opt;

        case (r_phase)
            PH_IDLE: begin
                if (i_in_byte == IAC) begin
                    n_phase = PH_IAC;
                end else begin
                    n_kind = KIND_DATA;
                    n_byte = i_in_byte;
                end
            end
            PH_IAC: begin
                if (i_in_byte == IAC) begin
                    n_phase = PH_IDLE;
                    n_kind  = KIND_DATA;
                    n_byte  = IAC;
                end else begin
                    cmd_byte = 1'b1;
                end
            end
            PH_OPT: begin
                n_opt = i_in_byte;
                if (r_cmd == CMD_SB) begin
                    n_phase   = PH_SUB;
                    n_sub_idx = '0;
                    for (int i = 0; i < 4; i++) begin
                        n_sub[i] = 8'd0;
                    end
                end else begin
                    n_phase = PH_IDLE;
                    run_cmd = 1'b1;
                    run_opt = i_in_byte;
                end
            end
            PH_SUB: begin
                store = 1'b1;
                if (i_in_byte == IAC) begin
                    n_phase = PH_SUB_IAC;
                end
            end
            PH_SUB_IAC: begin
                if (i_in_byte == IAC) begin
                    n_phase = PH_SUB;
                end else if (i_in_byte == CMD_SE) begin
                    store   = 1'b1;
                    n_phase = PH_IDLE;
                    run_cmd = 1'b1;
                end else begin
                    cmd_byte = 1'b1;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase

        if (cmd_byte) begin
            n_cmd = i_in_byte;
            n_opt = 8'd0;
            if (i_in_byte inside {CMD_WILL, CMD_WONT, CMD_DO, CMD_DONT, CMD_SB}) begin
                n_phase = PH_OPT;
            end else begin
                n_phase  = PH_IDLE;
                run_cmd  = 1'b1;
                run_code = i_in_byte;
                run_opt  = 8'd0;
            end
        end

        if (store && (r_sub_idx < SUB_W'(SUB_LEN - 1))) begin
            if (r_sub_idx < SUB_W'(4)) begin
                n_sub[r_sub_idx[1:0]] = i_in_byte;
            end
            n_sub_idx = r_sub_idx + SUB_W'(1);
        end

        if (run_cmd) begin
            case (run_code)
                CMD_SB: begin
                    if (run_opt == OPT_NAWS) begin
                        n_cols = {n_sub[0], n_sub[1]};
                        n_rows = {n_sub[2], n_sub[3]};
                    end
                end
                CMD_IP, CMD_BRK: begin
                    n_brk = r_basic;
                end
                CMD_DO: begin
                    n_reply = 1'b1;
                    if (run_opt == OPT_ECHO) begin
                        n_resp = CMD_WILL;
                        n_echo = 1'b1;
                    end else if (run_opt == OPT_BINARY || run_opt == OPT_SUP_GA) begin
                        n_resp = CMD_WILL;
                    end else begin
                        n_resp = CMD_WONT;
                    end
                end
                CMD_WILL: begin
                    if (run_opt != OPT_SUP_GA) begin
                        n_reply = 1'b1;
                        if (run_opt inside {[OPT_REFUSE_LO:OPT_REFUSE_HI]}) begin
                            n_resp = CMD_DONT;
                        end else begin
                            n_resp = CMD_DO;
                        end
                    end
                end
                default: begin
                end
            endcase
            n_count = r_count + 16'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_cmd       <= 8'd0;
            r_opt       <= 8'd0;
            r_sub_idx   <= '0;
            r_cols      <= 16'd0;
            r_rows      <= 16'd0;
            r_echo      <= 1'b0;
            r_count     <= 16'd0;
            r_basic     <= 1'b0;
            r_out_valid <= 1'b0;
            r_reply     <= 1'b0;
            r_brk       <= 1'b0;
            r_slot      <= SLOT_IAC;
        end else begin
            if (i_cfg_valid) begin
                r_basic <= i_cfg_data;
            end
            if (in_acc) begin
                r_phase     <= n_phase;
                r_cmd       <= n_cmd;
                r_opt       <= n_opt;
                r_sub_idx   <= n_sub_idx;
                r_cols      <= n_cols;
                r_rows      <= n_rows;
                r_echo      <= n_echo;
                r_count     <= n_count;
                r_out_valid <= 1'b1;
                r_reply     <= n_reply;
                r_brk       <= n_brk;
                r_slot      <= SLOT_IAC;
            end else if (out_acc) begin
                if (o_out_last) begin
                    r_out_valid <= 1'b0;
                end else if (r_slot == SLOT_IAC) begin
                    r_slot <= SLOT_RESP;
                end else begin
                    r_slot <= SLOT_OPT;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_sub  <= n_sub;
            r_kind <= n_kind;
            r_byte <= n_byte;
            r_resp <= n_resp;
        end
    end

    always_comb begin
        if (r_reply) begin
            o_out_kind = KIND_REPLY;
            case (r_slot)
                SLOT_IAC:  o_out_byte = IAC;
                SLOT_RESP: o_out_byte = r_resp;
                SLOT_OPT:  o_out_byte = r_opt;
                default:   o_out_byte = r_opt;
            endcase
        end else begin
            o_out_kind = r_kind;
            o_out_byte = r_byte;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_window_cols   = r_cols;
    assign o_window_rows   = r_rows;
    assign o_server_echo   = r_echo;
    assign o_break_request = r_brk;
    assign o_command_count = r_count;

endmodule
